### rtl/rdu_pkg.sv
// Shared types, constants and fixed-point helpers of the refraction direction unit.
package rdu_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int COMP_WIDTH  = 16;
   localparam int WIDE_W      = 32;
   localparam int DIV_STAGES  = 8;
   localparam int DIV_STEP    = 4;
   localparam int DIV_W       = DIV_STAGES * DIV_STEP;
   localparam int SQRT_STAGES = 8;
   localparam int SQRT_STEP   = 3;
   localparam int ROOT_W      = SQRT_STAGES * SQRT_STEP;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int SQREM_W     = ROOT_W + 2;

   localparam logic signed [63:0] ONE_FX  = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] HALF_FX = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
   localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;
   localparam logic signed [31:0] OUT_MAX = (32'sd1 <<< (COMP_WIDTH - 1)) - 32'sd1;
   localparam logic signed [31:0] OUT_MIN = -OUT_MAX - 32'sd1;

   typedef logic [2:0][COMP_WIDTH-1:0] vec_type;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] ray_x;
      logic signed [COMP_WIDTH-1:0] ray_y;
      logic signed [COMP_WIDTH-1:0] ray_z;
      logic signed [COMP_WIDTH-1:0] norm_x;
      logic signed [COMP_WIDTH-1:0] norm_y;
      logic signed [COMP_WIDTH-1:0] norm_z;
      logic [COMP_WIDTH-1:0]        index_from;
      logic [COMP_WIDTH-1:0]        index_into;
   } req_type;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] dir_x;
      logic signed [COMP_WIDTH-1:0] dir_y;
      logic signed [COMP_WIDTH-1:0] dir_z;
      logic                         total_reflect;
   } rsp_type;

   // Travels alongside the divider.
   typedef struct packed {
      vec_type ray;
      vec_type nrm;
   } div_side_type;

   // Travels alongside the square root.
   typedef struct packed {
      logic [2:0][WIDE_W-1:0] tr;
      vec_type                nrm;
      logic                   tir;
   } sqrt_side_type;

   // Round to FRAC_BITS fraction bits, halves toward plus infinity.
   function automatic logic signed [63:0] round_frac(input logic signed [63:0] x);
      round_frac = (x + HALF_FX) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [63:0] x);
      if (x > WIDE_MAX) begin
         sat_wide = WIDE_W'(WIDE_MAX);
      end else if (x < WIDE_MIN) begin
         sat_wide = WIDE_W'(WIDE_MIN);
      end else begin
         sat_wide = x[WIDE_W-1:0];
      end
   endfunction

   function automatic logic signed [COMP_WIDTH-1:0] sat_comp(
      input logic signed [WIDE_W-1:0] x);
      if (x > OUT_MAX) begin
         sat_comp = OUT_MAX[COMP_WIDTH-1:0];
      end else if (x < OUT_MIN) begin
         sat_comp = OUT_MIN[COMP_WIDTH-1:0];
      end else begin
         sat_comp = x[COMP_WIDTH-1:0];
      end
   endfunction

endpackage

### rtl/rdu_divider.sv
// Pipelined restoring divider for the index ratio, several quotient bits per stage.
module rdu_divider (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [rdu_pkg::DIV_W-1:0]  num_word,
   input  logic [rdu_pkg::COMP_WIDTH-1:0] den_word,
   input  rdu_pkg::div_side_type      side_word,
   output logic [rdu_pkg::DIV_W-1:0]  quo_word,
   output rdu_pkg::div_side_type      side_out
);
   localparam int NS = rdu_pkg::DIV_STAGES;
   localparam int QW = rdu_pkg::DIV_W;
   localparam int DW = rdu_pkg::COMP_WIDTH;

   logic [DW-1:0]         rem_ff  [NS];
   logic [DW-1:0]         den_ff  [NS];
   logic [QW-1:0]         quo_ff  [NS];
   logic [QW-1:0]         num_ff  [NS];
   rdu_pkg::div_side_type side_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [DW-1:0]         rem_src, den_src, rem_in;
      logic [QW-1:0]         quo_src, num_src, quo_in, num_in;
      logic [DW:0]           shift;
      rdu_pkg::div_side_type side_src;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign quo_src  = '0;
         assign num_src  = num_word;
         assign den_src  = den_word;
         assign side_src = side_word;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign num_src  = num_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // a zero divisor always subtracts, so the quotient comes out all ones
      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         num_in = num_src;
         shift  = '0;
         for (int j = 0; j < rdu_pkg::DIV_STEP; j++) begin
            shift  = {rem_in, num_in[QW-1]};
            num_in = {num_in[QW-2:0], 1'b0};
            if (shift >= {1'b0, den_src}) begin
               rem_in = DW'(shift - {1'b0, den_src});
               quo_in = {quo_in[QW-2:0], 1'b1};
            end else begin
               rem_in = shift[DW-1:0];
               quo_in = {quo_in[QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            num_ff[s]  <= num_in;
            den_ff[s]  <= den_src;
            side_ff[s] <= side_src;
         end
      end
   end

   assign quo_word = quo_ff[NS-1];
   assign side_out = side_ff[NS-1];

endmodule

### rtl/rdu_sqrt.sv
// Pipelined digit-by-digit integer square root, several root bits per stage.
module rdu_sqrt (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [rdu_pkg::RAD_W-1:0]    rad_word,
   input  rdu_pkg::sqrt_side_type       side_word,
   output logic [rdu_pkg::ROOT_W-1:0]   root_word,
   output logic [rdu_pkg::SQREM_W-1:0]  rem_word,
   output rdu_pkg::sqrt_side_type       side_out
);
   localparam int NS = rdu_pkg::SQRT_STAGES;
   localparam int RW = rdu_pkg::ROOT_W;
   localparam int XW = rdu_pkg::RAD_W;
   localparam int MW = rdu_pkg::SQREM_W;

   logic [RW-1:0]          root_ff [NS];
   logic [MW-1:0]          rem_ff  [NS];
   logic [XW-1:0]          rad_ff  [NS];
   rdu_pkg::sqrt_side_type side_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [RW-1:0]          root_src, root_in;
      logic [MW-1:0]          rem_src, rem_in;
      logic [XW-1:0]          rad_src, rad_in;
      logic [MW+1:0]          shift, trial;
      rdu_pkg::sqrt_side_type side_src;

      if (s == 0) begin : g_first
         assign root_src = '0;
         assign rem_src  = '0;
         assign rad_src  = rad_word;
         assign side_src = side_word;
      end else begin : g_next
         assign root_src = root_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         root_in = root_src;
         rem_in  = rem_src;
         rad_in  = rad_src;
         shift   = '0;
         trial   = '0;
         for (int j = 0; j < rdu_pkg::SQRT_STEP; j++) begin
            shift  = {rem_in, rad_in[XW-1:XW-2]};
            rad_in = {rad_in[XW-3:0], 2'b00};
            trial  = (MW+2)'({root_in, 2'b01});
            if (shift >= trial) begin
               rem_in  = MW'(shift - trial);
               root_in = {root_in[RW-2:0], 1'b1};
            end else begin
               rem_in  = shift[MW-1:0];
               root_in = {root_in[RW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[s] <= root_in;
            rem_ff[s]  <= rem_in;
            rad_ff[s]  <= rad_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign root_word = root_ff[NS-1];
   assign rem_word  = rem_ff[NS-1];
   assign side_out  = side_ff[NS-1];

endmodule

### rtl/refraction_direction_unit.sv
// Top level of the refraction direction unit: Snell refraction of one ray per cycle.
//
// Takes a ray direction I, a unit normal N (pointing to the transmitted side)
// and two refractive indices, all Q2.14, and returns sqrt(k)*N + r*(I - c*N)
// with r = n_from/n_into, c = N.I, k = 1 - r*r*(1 - c*c). When k < 0 the
// word carries total_reflect = 1 and a zero direction. Every intermediate is
// rounded (halves up) and saturated to 32 bits; the outputs saturate to 16.
// A zero destination index gives the largest ratio. The unit is a 24-stage
// pipeline: 8 divider stages of 4 quotient bits for the ratio, 6 stages of
// products and sums, 8 square-root stages of 3 root bits, and 2 closing
// stages, followed by a 2-word output buffer. A new word is taken every cycle.
// The pipeline stalls as a whole only when the output buffer holds two words
// that are not yet taken.
module refraction_direction_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rdu_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rdu_pkg::rsp_type rsp_word
);
   localparam int FB  = rdu_pkg::FRAC_BITS;
   localparam int CW  = rdu_pkg::COMP_WIDTH;
   localparam int WW  = rdu_pkg::WIDE_W;
   localparam int QW  = rdu_pkg::DIV_W;
   localparam int RW  = rdu_pkg::ROOT_W;
   localparam int NST = rdu_pkg::DIV_STAGES + 6 + rdu_pkg::SQRT_STAGES + 2;

   // ---------------- pipeline control ----------------
   logic [NST-1:0] v_ff;
   logic [1:0]     cnt_ff, cnt_in;
   logic           wr_ptr_ff, rd_ptr_ff;
   logic           adv, push, pop;

   assign adv       = (cnt_ff != 2'd2);
   assign req_ready = adv;
   assign push      = adv & v_ff[NST-1];
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      priority if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (adv) begin
            v_ff <= {v_ff[NST-2:0], req_valid};
         end
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // ---------------- ratio divider ----------------
   logic [QW-1:0]         div_num, div_quo;
   rdu_pkg::div_side_type div_side, div_side_q;

   // numerator is from*2^FB plus half the divisor, for round to nearest
   assign div_num = (QW'(req_word.index_from) << FB) + QW'(req_word.index_into >> 1);
   assign div_side.ray = {req_word.ray_z, req_word.ray_y, req_word.ray_x};
   assign div_side.nrm = {req_word.norm_z, req_word.norm_y, req_word.norm_x};

   rdu_divider u_div (
      .clock     (clock),
      .adv       (adv),
      .num_word  (div_num),
      .den_word  (req_word.index_into),
      .side_word (div_side),
      .quo_word  (div_quo),
      .side_out  (div_side_q)
   );

   // ---------------- P1: r*r and the three N.I products ----------------
   logic [QW-2:0]        ratio1_ff;
   logic signed [WW-1:0] rsq1_ff;
   logic signed [WW-1:0] prd1_ff [3];
   rdu_pkg::vec_type     ray1_ff, nrm1_ff;
   logic [2*QW-3:0]      rsq_prod;
   logic signed [2*CW-1:0] dot_prod [3];

   always_comb begin
      rsq_prod = div_quo[QW-2:0] * div_quo[QW-2:0];
      for (int c = 0; c < 3; c++) begin
         dot_prod[c] = $signed(div_side_q.ray[c]) * $signed(div_side_q.nrm[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // a quotient fits 31 bits; a zero divisor's all-ones quotient becomes the largest wide value
         ratio1_ff <= div_quo[QW-2:0];
         rsq1_ff   <= rdu_pkg::sat_wide(rdu_pkg::round_frac($signed(64'(rsq_prod))));
         for (int c = 0; c < 3; c++) begin
            prd1_ff[c] <= rdu_pkg::sat_wide(rdu_pkg::round_frac(64'(dot_prod[c])));
         end
         ray1_ff <= div_side_q.ray;
         nrm1_ff <= div_side_q.nrm;
      end
   end

   // ---------------- P2: cosine ----------------
   logic [QW-2:0]        ratio2_ff;
   logic signed [WW-1:0] rsq2_ff, cos2_ff;
   rdu_pkg::vec_type     ray2_ff, nrm2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ratio2_ff <= ratio1_ff;
         rsq2_ff   <= rsq1_ff;
         cos2_ff   <= rdu_pkg::sat_wide(64'(prd1_ff[0]) + 64'(prd1_ff[1]) + 64'(prd1_ff[2]));
         ray2_ff   <= ray1_ff;
         nrm2_ff   <= nrm1_ff;
      end
   end

   // ---------------- P3: c*c and c*N ----------------
   logic [QW-2:0]        ratio3_ff;
   logic signed [WW-1:0] rsq3_ff, csq3_ff;
   logic signed [WW-1:0] along3_ff [3];
   rdu_pkg::vec_type     ray3_ff, nrm3_ff;
   logic signed [63:0]   csq_prod;
   logic signed [WW+CW-1:0] along_prod [3];

   always_comb begin
      csq_prod = cos2_ff * cos2_ff;
      for (int c = 0; c < 3; c++) begin
         along_prod[c] = cos2_ff * $signed(nrm2_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ratio3_ff <= ratio2_ff;
         rsq3_ff   <= rsq2_ff;
         csq3_ff   <= rdu_pkg::sat_wide(rdu_pkg::round_frac(csq_prod));
         for (int c = 0; c < 3; c++) begin
            along3_ff[c] <= rdu_pkg::sat_wide(rdu_pkg::round_frac(64'(along_prod[c])));
         end
         ray3_ff <= ray2_ff;
         nrm3_ff <= nrm2_ff;
      end
   end

   // ---------------- P4: 1 - c*c and I - c*N ----------------
   logic [QW-2:0]        ratio4_ff;
   logic signed [WW-1:0] rsq4_ff, sin4_ff;
   logic signed [WW-1:0] tang4_ff [3];
   rdu_pkg::vec_type     nrm4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ratio4_ff <= ratio3_ff;
         rsq4_ff   <= rsq3_ff;
         sin4_ff   <= rdu_pkg::sat_wide(rdu_pkg::ONE_FX - 64'(csq3_ff));
         for (int c = 0; c < 3; c++) begin
            tang4_ff[c] <= rdu_pkg::sat_wide(64'($signed(ray3_ff[c])) - 64'(along3_ff[c]));
         end
         nrm4_ff <= nrm3_ff;
      end
   end

   // ---------------- P5: r*r*(1 - c*c) and r*(I - c*N) ----------------
   logic signed [WW-1:0] m5_ff;
   logic signed [WW-1:0] tr5_ff [3];
   rdu_pkg::vec_type     nrm5_ff;
   logic signed [63:0]   m_prod;
   logic signed [63:0]   tr_prod [3];

   always_comb begin
      // r*r is saturated nonnegative, so its sign bit is clear
      m_prod = rsq4_ff * sin4_ff;
      for (int c = 0; c < 3; c++) begin
         tr_prod[c] = $signed({1'b0, ratio4_ff}) * tang4_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m5_ff <= rdu_pkg::sat_wide(rdu_pkg::round_frac(m_prod));
         for (int c = 0; c < 3; c++) begin
            tr5_ff[c] <= rdu_pkg::sat_wide(rdu_pkg::round_frac(tr_prod[c]));
         end
         nrm5_ff <= nrm4_ff;
      end
   end

   // ---------------- P6: radicand and reflection test ----------------
   logic signed [WW-1:0]   rad_val;
   logic [rdu_pkg::RAD_W-1:0] rad6_ff;
   rdu_pkg::sqrt_side_type side6_ff;

   assign rad_val = rdu_pkg::sat_wide(rdu_pkg::ONE_FX - 64'(m5_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         // root of k*2^FB keeps FB fraction bits in the result
         rad6_ff      <= rdu_pkg::RAD_W'(rad_val[WW-2:0]) << FB;
         side6_ff.tir <= rad_val[WW-1];
         side6_ff.nrm <= nrm5_ff;
         for (int c = 0; c < 3; c++) begin
            side6_ff.tr[c] <= tr5_ff[c];
         end
      end
   end

   // ---------------- square root ----------------
   logic [RW-1:0]              sq_root;
   logic [rdu_pkg::SQREM_W-1:0] sq_rem;
   rdu_pkg::sqrt_side_type     sq_side;

   rdu_sqrt u_sqrt (
      .clock     (clock),
      .adv       (adv),
      .rad_word  (rad6_ff),
      .side_word (side6_ff),
      .root_word (sq_root),
      .rem_word  (sq_rem),
      .side_out  (sq_side)
   );

   // ---------------- Q0: round the root to nearest ----------------
   logic [RW:0]            root0_ff;
   rdu_pkg::sqrt_side_type side0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         root0_ff <= {1'b0, sq_root} + (RW+1)'(sq_rem > rdu_pkg::SQREM_W'(sq_root));
         side0_ff <= sq_side;
      end
   end

   // ---------------- Q1: sqrt(k)*N ----------------
   logic signed [WW-1:0] a1_ff [3];
   logic signed [WW-1:0] b1_ff [3];
   logic                 tir1_ff;
   logic signed [RW+CW+1:0] a_prod [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         a_prod[c] = $signed({1'b0, root0_ff}) * $signed(side0_ff.nrm[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            a1_ff[c] <= rdu_pkg::sat_wide(rdu_pkg::round_frac(64'(a_prod[c])));
            b1_ff[c] <= $signed(side0_ff.tr[c]);
         end
         tir1_ff <= side0_ff.tir;
      end
   end

   // ---------------- final sum, saturation and output buffer ----------------
   logic signed [CW-1:0] dir [3];
   rdu_pkg::rsp_type     fin_word;
   rdu_pkg::rsp_type     fifo_ff [2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dir[c] = tir1_ff ? '0 :
                  rdu_pkg::sat_comp(rdu_pkg::sat_wide(64'(a1_ff[c]) + 64'(b1_ff[c])));
      end
      fin_word.dir_x         = dir[0];
      fin_word.dir_y         = dir[1];
      fin_word.dir_z         = dir[2];
      fin_word.total_reflect = tir1_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= fin_word;
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_word  = fifo_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.total_reflect) |->
      (rsp_word.dir_x == '0 && rsp_word.dir_y == '0 && rsp_word.dir_z == '0))
      else $error("reflected word carries a nonzero direction");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline moved while stalled");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[0])
      else $error("accepted word missing from first stage");
`endif

endmodule

### verif/rdu_checker.sv
// Checker of the refraction direction unit: predicts each response word and compares it.
module rdu_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rdu_pkg::req_type req_word,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rdu_pkg::rsp_type rsp_word,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   rdu_pkg::rsp_type refracted_q[$];

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Product rounded to nearest with halves up, then clipped.
   function automatic longint qmul(input longint p, input longint q);
      longint x;
      x = p * q + (64'sd1 <<< (rdu_pkg::FRAC_BITS - 1));
      return clip32(x >>> rdu_pkg::FRAC_BITS);
   endfunction

   function automatic longint isqrt_near(input longint unsigned x);
      longint unsigned lo, hi, mid;
      lo = 64'd0;
      hi = 64'd4294967295;
      while (lo < hi) begin
         mid = (lo + hi + 64'd1) >> 1;
         if (mid * mid <= x) lo = mid;
         else hi = mid - 64'd1;
      end
      if (x - lo * lo > lo) lo++;
      return longint'(lo);
   endfunction

   function automatic rdu_pkg::rsp_type refract(input rdu_pkg::req_type w);
      longint ray[3], nrm[3];
      longint one, cosv, ratio, ratio_sq, sin_sq, rad, root, along, tang, d;
      longint unsigned from, into;
      rdu_pkg::rsp_type r;
      one = 64'sd1 <<< rdu_pkg::FRAC_BITS;
      ray[0] = longint'(w.ray_x);  ray[1] = longint'(w.ray_y);
      ray[2] = longint'(w.ray_z);
      nrm[0] = longint'(w.norm_x); nrm[1] = longint'(w.norm_y);
      nrm[2] = longint'(w.norm_z);
      from = 64'(w.index_from);
      into = 64'(w.index_into);
      cosv = clip32(qmul(ray[0], nrm[0]) + qmul(ray[1], nrm[1]) + qmul(ray[2], nrm[2]));
      if (into == 0) ratio = 64'sd2147483647;
      else ratio = clip32(longint'(((from << rdu_pkg::FRAC_BITS) + (into >> 1)) / into));
      ratio_sq = qmul(ratio, ratio);
      sin_sq = clip32(one - qmul(cosv, cosv));
      rad = clip32(one - qmul(ratio_sq, sin_sq));
      r = '0;
      if (rad < 0) begin
         r.total_reflect = 1'b1;
         return r;
      end
      root = isqrt_near(longint'(rad) << rdu_pkg::FRAC_BITS);
      for (int c = 0; c < 3; c++) begin
         along = qmul(cosv, nrm[c]);
         tang = clip32(ray[c] - along);
         d = clip32(qmul(root, nrm[c]) + qmul(ratio, tang));
         if (d > 32767) d = 32767;
         if (d < -32768) d = -32768;
         if (c == 0) r.dir_x = d[15:0];
         else if (c == 1) r.dir_y = d[15:0];
         else r.dir_z = d[15:0];
      end
      return r;
   endfunction

   assign pending = refracted_q.size();

   always_ff @(posedge clock) begin
      rdu_pkg::rsp_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) refracted_q.push_back(refract(req_word));
         if (rsp_valid && rsp_ready) begin
            if (refracted_q.size() == 0) begin
               $error("response word with nothing expected: %h", rsp_word);
               fail_count <= fail_count + 1;
            end else begin
               e = refracted_q.pop_front();
               if (e !== rsp_word) begin
                  if (e.dir_x !== rsp_word.dir_x)
                     $error("dir_x expected %0d actual %0d", e.dir_x, rsp_word.dir_x);
                  if (e.dir_y !== rsp_word.dir_y)
                     $error("dir_y expected %0d actual %0d", e.dir_y, rsp_word.dir_y);
                  if (e.dir_z !== rsp_word.dir_z)
                     $error("dir_z expected %0d actual %0d", e.dir_z, rsp_word.dir_z);
                  if (e.total_reflect !== rsp_word.total_reflect)
                     $error("total_reflect expected %0d actual %0d",
                            e.total_reflect, rsp_word.total_reflect);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### verif/tb.sv
// Testbench top of the refraction direction unit: stimulus, stalls and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM  = 1000;
   localparam int TAIL_ITEMS = 150;   // last items run with no idling
   localparam int STUCK_MAX = 2000;   // cycles without any handshake
   localparam int LATENCY   = 24;

   logic             clock, reset;
   logic             req_valid, req_ready, rsp_valid, rsp_ready;
   rdu_pkg::req_type req_word;
   rdu_pkg::rsp_type rsp_word;
   int               fail_count, pending;
   bit               calm;            // no idling in the closing stretch
   bit               stall_long_done;

   refraction_direction_unit i_dut (.*);

   rdu_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Unit-ish vector: a random Q2.14 direction roughly normalized.
   function automatic rdu_pkg::req_type snell_case();
      rdu_pkg::req_type w;
      int ax, ay, az;
      w = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         // normal along z-ish, ray roughly crossing it
         ax = int'($urandom_range(0, 12000)) - 6000;
         ay = int'($urandom_range(0, 12000)) - 6000;
         az = int'($urandom_range(12000, 16384));
         w.norm_x = 16'(ax); w.norm_y = 16'(ay); w.norm_z = 16'(az);
         w.ray_x = 16'(int'($urandom_range(0, 24000)) - 12000);
         w.ray_y = 16'(int'($urandom_range(0, 24000)) - 12000);
         w.ray_z = 16'($urandom_range(8000, 16384));
         w.index_from = 16'($urandom_range(16384, 28000));   // 1.0 .. ~1.7
         w.index_into = 16'($urandom_range(16384, 28000));
      end
      return w;
   endfunction

   task automatic send_word(input rdu_pkg::req_type w);
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Receiver: random stall bursts, one long hold-off to fill the pipe.
   initial begin
      rsp_ready = 1'b0;
      stall_long_done = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!stall_long_done && pending > 10) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            stall_long_done = 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on handshake progress.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= STUCK_MAX) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      rdu_pkg::req_type w;
      int unsigned edge_vals[4];
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      edge_vals = '{32'h8000, 32'h7fff, 32'h0000, 32'hffff};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, zero indices, head-on ray, reflection, index extremes, out-of-range vectors.
      for (int k = 0; k < 4; k++) begin
         w = {8{edge_vals[k][15:0]}};
         send_word(w);
      end
      w = '0; w.norm_z = 16'sd16384; w.ray_z = 16'sd16384;
      w.index_from = 16'd16384; w.index_into = 16'd16384;
      send_word(w);                                  // straight through
      w.index_into = 16'd0;  send_word(w);           // destination index zero
      w.index_into = 16'd16384; w.index_from = 16'd0; w.ray_x = 16'sd16384;
      send_word(w);                                  // source index zero
      w = '0; w.norm_z = 16'sd16384; w.ray_x = 16'sd15000; w.ray_z = 16'sd6000;
      w.index_from = 16'd24576; w.index_into = 16'd16384;
      send_word(w);                                  // total internal reflection
      w.index_from = 16'hffff; w.index_into = 16'd1; send_word(w);
      w.index_from = 16'd1; w.index_into = 16'hffff; send_word(w);
      w = '0; w.norm_x = 16'sh8000; w.ray_x = 16'sh7fff;
      w.index_from = 16'd16384; w.index_into = 16'd16384;
      send_word(w);                                  // out-of-range vectors

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - TAIL_ITEMS) calm = 1'b1;
         send_word(snell_case());
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
